/* design/brop_pkg.sv */
// ----------------------------------------------------------------------------
// brop_pkg
// Shared types, constants and helper functions of the raster-op row unit.
// ----------------------------------------------------------------------------
package brop_pkg;

    localparam int WORD_BITS    = 32;
    localparam int MAX_ROW_BITS = 8192;
    localparam int ROW_W        = 14;
    localparam int WL_W         = 9;
    localparam int SHIFT_W      = 5;
    localparam int IDX_W        = 3;
    localparam int CFG_IDX_W    = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_OP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_BIT_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BIT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH_BITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LOG_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_LOG_DEPTH  = 3'd5;

    localparam logic [3:0]       ROP_COPY_SOURCE = 4'd12;
    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 14'd32;

    typedef struct packed {
        logic [3:0]         raster_op;
        logic [SHIFT_W-1:0] dst_bit_offset;
        logic [SHIFT_W-1:0] src_bit_offset;
        logic [ROW_W-1:0]   row_width_bits;
        logic [1:0]         src_log_depth;
        logic [1:0]         dst_log_depth;
    } cfg_t;

    // one destination word handed from the front to the back
    typedef struct packed {
        logic [WORD_BITS-1:0] aligned;
        logic [IDX_W-1:0]     idx;
        logic [WORD_BITS-1:0] dst;
        logic                 first;
        logic                 last;
        logic                 taken;
    } entry_t;

    function automatic logic [ROW_W-1:0] eff_width(input logic [ROW_W-1:0] w);
        logic [ROW_W-1:0] r;
        r = w;
        if (w == '0)
            r = ROW_W'(1);
        else if (w > ROW_W'(MAX_ROW_BITS))
            r = ROW_W'(MAX_ROW_BITS);
        return r;
    endfunction

    function automatic logic [1:0] eff_src_depth(input cfg_t c);
        return (c.src_log_depth > c.dst_log_depth) ? c.dst_log_depth : c.src_log_depth;
    endfunction

    function automatic logic [1:0] depth_diff(input cfg_t c);
        return 2'(c.dst_log_depth - eff_src_depth(c));
    endfunction

endpackage

/* design/brop_front.sv */
// ----------------------------------------------------------------------------
// brop_front
// Accepts items, tracks the row state and funnel-shifts the source words.
// ----------------------------------------------------------------------------
module brop_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  brop_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_mode,
    input  logic [brop_pkg::WORD_BITS-1:0]   in_src,
    input  logic [brop_pkg::WORD_BITS-1:0]   in_dst,
    input  logic                             q_ready,
    output logic                             q_push,
    output brop_pkg::entry_t                 q_entry
);

    logic [brop_pkg::WORD_BITS-1:0] carry_word_reg, carry_word_next;
    logic [brop_pkg::WORD_BITS-1:0] aligned_source_reg, aligned_source_next;
    logic [brop_pkg::IDX_W-1:0]     expand_left_reg, expand_left_next;
    logic [brop_pkg::WL_W-1:0]      words_left_reg, words_left_next;
    logic                           first_word_reg, first_word_next;

    logic                           accept;
    logic [1:0]                     dd;
    logic [3:0]                     nw;
    logic [brop_pkg::IDX_W-1:0]     nw_low;
    logic [brop_pkg::SHIFT_W-1:0]   doff_scaled;
    logic [5:0]                     delta;
    logic [5:0]                     rshift;
    logic [2*brop_pkg::WORD_BITS-1:0] funnel;
    logic [brop_pkg::WORD_BITS-1:0] shifted;
    logic [brop_pkg::ROW_W-1:0]     width;
    logic [brop_pkg::ROW_W:0]       span;
    logic [brop_pkg::IDX_W-1:0]     idx;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        dd          = brop_pkg::depth_diff(cfg);
        nw          = 4'(1) << dd;
        nw_low      = brop_pkg::IDX_W'(nw - 4'(1));
        doff_scaled = cfg.dst_bit_offset >> dd;
        delta       = {1'b0, cfg.src_bit_offset} - {1'b0, doff_scaled};
        // right shift of {carry, src} that lines the source up
        rshift      = delta[5] ? (6'd0 - delta) : (6'd32 - delta);
        funnel      = {carry_word_reg, in_src} >> rshift;
        shifted     = funnel[brop_pkg::WORD_BITS-1:0];
        width       = brop_pkg::eff_width(cfg.row_width_bits);
        span        = (brop_pkg::ROW_W+1)'(cfg.dst_bit_offset)
                    + (brop_pkg::ROW_W+1)'(width) - (brop_pkg::ROW_W+1)'(1);
        idx         = (brop_pkg::IDX_W'(nw) - expand_left_reg) & nw_low;

        carry_word_next     = carry_word_reg;
        aligned_source_next = aligned_source_reg;
        expand_left_next    = expand_left_reg;
        words_left_next     = words_left_reg;
        first_word_next     = first_word_reg;
        q_push              = 1'b0;

        q_entry.aligned = aligned_source_reg;
        q_entry.idx     = idx;
        q_entry.dst     = in_dst;
        q_entry.first   = first_word_reg;
        q_entry.last    = (words_left_reg == brop_pkg::WL_W'(1));
        q_entry.taken   = 1'b0;

        if (accept && !in_mode)
        begin
            words_left_next  = brop_pkg::WL_W'(span[brop_pkg::ROW_W:5]) + brop_pkg::WL_W'(1);
            first_word_next  = 1'b1;
            expand_left_next = '0;
            carry_word_next  = delta[5] ? '0 : in_src;
        end
        else if (accept && words_left_reg != '0)
        begin
            q_push = 1'b1;
            if (expand_left_reg == '0)
            begin
                carry_word_next     = in_src;
                aligned_source_next = shifted;
                expand_left_next    = nw_low;
                q_entry.aligned     = shifted;
                q_entry.idx         = '0;
                q_entry.taken       = 1'b1;
            end
            else
            begin
                expand_left_next = expand_left_reg - brop_pkg::IDX_W'(1);
            end
            first_word_next = 1'b0;
            words_left_next = words_left_reg - brop_pkg::WL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_word_reg     <= '0;
            aligned_source_reg <= '0;
            expand_left_reg    <= '0;
            words_left_reg     <= '0;
            first_word_reg     <= 1'b1;
        end
        else
        begin
            carry_word_reg     <= carry_word_next;
            aligned_source_reg <= aligned_source_next;
            expand_left_reg    <= expand_left_next;
            words_left_reg     <= words_left_next;
            first_word_reg     <= first_word_next;
        end
    end

    a_words_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        words_left_reg <= brop_pkg::WL_W'(257))
        else $error("row word count out of range");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_entry.last |=> words_left_reg == '0)
        else $error("row did not end after its last word");

endmodule

/* design/brop_queue.sv */
// ----------------------------------------------------------------------------
// brop_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module brop_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  brop_pkg::entry_t push_entry,
    output logic             ready,
    input  logic             pop,
    output logic             valid,
    output brop_pkg::entry_t head
);

    brop_pkg::entry_t slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign ready   = (count_reg != 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count overflow");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not grow on push");

endmodule

/* design/brop_back.sv */
// ----------------------------------------------------------------------------
// brop_back
// Expands source pixels, applies the raster op and edge masks, holds the result.
// ----------------------------------------------------------------------------
module brop_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  brop_pkg::cfg_t                 cfg,
    input  logic                           q_valid,
    input  brop_pkg::entry_t               q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [brop_pkg::WORD_BITS-1:0] out_word,
    output logic                           out_taken,
    output logic                           out_last
);

    logic                           out_valid_reg, out_valid_next;
    logic [brop_pkg::WORD_BITS-1:0] out_word_reg;
    logic                           out_taken_reg;
    logic                           out_last_reg;

    logic [1:0]                     sdep;
    logic [1:0]                     dd;
    logic [5:0]                     seg_bits;
    logic [8:0]                     used_bits;
    logic [5:0]                     seg_shift;
    logic [brop_pkg::WORD_BITS-1:0] seg;
    logic [brop_pkg::WORD_BITS-1:0] expanded;
    logic [brop_pkg::WORD_BITS-1:0] rop_word;
    logic [brop_pkg::WORD_BITS-1:0] lmask;
    logic [brop_pkg::WORD_BITS-1:0] rmask;
    logic [brop_pkg::WORD_BITS-1:0] mask;
    logic [brop_pkg::WORD_BITS-1:0] s;
    logic [brop_pkg::WORD_BITS-1:0] d;
    logic [brop_pkg::ROW_W-1:0]     width;
    logic [brop_pkg::ROW_W-1:0]     end_sum;
    logic [brop_pkg::SHIFT_W-1:0]   end_bit;
    logic [brop_pkg::SHIFT_W-1:0]   pix_sel;
    logic [brop_pkg::SHIFT_W-1:0]   low_mask;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        sdep      = brop_pkg::eff_src_depth(cfg);
        dd        = brop_pkg::depth_diff(cfg);
        // the expanded word idx comes from the segment counted from the MSB
        seg_bits  = 6'(brop_pkg::WORD_BITS >> dd);
        used_bits = 9'(seg_bits) * (9'(q_head.idx) + 9'd1);
        seg_shift = 6'(9'(brop_pkg::WORD_BITS) - used_bits);
        seg       = q_head.aligned >> seg_shift;
        low_mask  = brop_pkg::SHIFT_W'((6'd1 << sdep) - 6'd1);
        for (int j = 0; j < brop_pkg::WORD_BITS; j++)
        begin
            pix_sel     = ((brop_pkg::SHIFT_W'(j) >> (sdep + dd)) << sdep)
                        | (brop_pkg::SHIFT_W'(j) & low_mask);
            expanded[j] = seg[pix_sel];
        end
        if (dd == 2'd0)
            expanded = q_head.aligned;

        s        = expanded;
        d        = q_head.dst;
        rop_word = ({brop_pkg::WORD_BITS{cfg.raster_op[0]}} & ~s & ~d)
                 | ({brop_pkg::WORD_BITS{cfg.raster_op[1]}} & ~s &  d)
                 | ({brop_pkg::WORD_BITS{cfg.raster_op[2]}} &  s & ~d)
                 | ({brop_pkg::WORD_BITS{cfg.raster_op[3]}} &  s &  d);

        width   = brop_pkg::eff_width(cfg.row_width_bits);
        end_sum = brop_pkg::ROW_W'(cfg.dst_bit_offset) + width;
        end_bit = end_sum[brop_pkg::SHIFT_W-1:0];
        lmask   = '1 >> cfg.dst_bit_offset;
        rmask   = (end_bit == '0) ? '1 : ('1 << (6'd32 - 6'(end_bit)));
        mask    = q_head.first ? lmask : '1;
        if (q_head.last)
            mask = mask & rmask;

        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_word_reg  <= (q_head.dst & ~mask) | (rop_word & mask);
            out_taken_reg <= q_head.taken;
            out_last_reg  <= q_head.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_taken = out_taken_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/bitblt_raster_op_row_unit.sv */
// ----------------------------------------------------------------------------
// bitblt_raster_op_row_unit
// Row datapath of a 32-bit word bit-block transfer with 16 raster ops.
// ----------------------------------------------------------------------------
// Usage:
//   Write the registers through cfg_we / cfg_index / cfg_data while idle.
//   Send one row-start item (tuser = 0, tdata = first source word), then one
//   item per destination word (tuser = 1, tdata = {dst_word, src_word}).
//   Each destination word inside the row returns one result on the master
//   side: tdata is the new destination word, tuser says whether src_word
//   was consumed, tlast marks the rightmost word of the row. Row starts and
//   words past the row end return nothing.
//   Throughput is one item per cycle while the queue has room. A request
//   passes the queue write, then the output register, before m_axis_tvalid
//   rises with its result.
//   When the receiver stalls, the result is held in the output register and
//   the two-entry queue fills; s_axis_tready drops once the queue is full.
//   Reset clears the row state and restores the register defaults
//   (copy source, 32-bit row, zero offsets, 1 bit per pixel).
// ----------------------------------------------------------------------------
module bitblt_raster_op_row_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [brop_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [brop_pkg::ROW_W-1:0]        cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,  // src_word, dst_word
    input  logic                              s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // new_dst_word
    output logic                              m_axis_tuser,  // source_taken
    output logic                              m_axis_tlast
);

    brop_pkg::cfg_t   cfg_reg, cfg_next;
    brop_pkg::entry_t push_entry;
    brop_pkg::entry_t head;
    logic             push;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                brop_pkg::CFG_RASTER_OP:      cfg_next.raster_op      = cfg_data[3:0];
                brop_pkg::CFG_DST_BIT_OFFSET: cfg_next.dst_bit_offset = cfg_data[4:0];
                brop_pkg::CFG_SRC_BIT_OFFSET: cfg_next.src_bit_offset = cfg_data[4:0];
                brop_pkg::CFG_ROW_WIDTH_BITS: cfg_next.row_width_bits = cfg_data;
                brop_pkg::CFG_SRC_LOG_DEPTH:  cfg_next.src_log_depth  = cfg_data[1:0];
                brop_pkg::CFG_DST_LOG_DEPTH:  cfg_next.dst_log_depth  = cfg_data[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raster_op      <= brop_pkg::ROP_COPY_SOURCE;
            cfg_reg.dst_bit_offset <= '0;
            cfg_reg.src_bit_offset <= '0;
            cfg_reg.row_width_bits <= brop_pkg::ROW_WIDTH_RESET;
            cfg_reg.src_log_depth  <= '0;
            cfg_reg.dst_log_depth  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brop_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_mode  (s_axis_tuser),
        .in_src   (s_axis_tdata[31:0]),
        .in_dst   (s_axis_tdata[63:32]),
        .q_ready  (q_ready),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    brop_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .ready      (q_ready),
        .pop        (pop),
        .valid      (q_valid),
        .head       (head)
    );

    brop_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (head),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_taken (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

/* tb/tb_bitblt_raster_op_row_unit.sv */
// ----------------------------------------------------------------------------
// tb_bitblt_raster_op_row_unit
// Self-checking bench for the raster-op row unit. A scoreboard predicts each
// destination word from the funnel shift, pixel widening, boolean op and edge
// masks, and compares the results in order. A directed part covers every op
// and the corner cases. Random rows with random idling on both sides follow.
// ----------------------------------------------------------------------------
module tb_bitblt_raster_op_row_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit MODE_ROW_START = 1'b0;
    localparam bit MODE_DST_WORD  = 1'b1;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 80;
    localparam int RANDOM_ITEMS   = 900;

    typedef struct packed {
        logic [31:0] word;
        logic        taken;
        logic        last;
    } row_word_t;

    class row_raster_model;
        brop_pkg::cfg_t regs;
        logic [31:0]    carry_word;
        logic [31:0]    aligned_src;
        int unsigned    expand_left;
        int unsigned    words_left;
        bit             first_word;
        row_word_t      expected_words[$];
        int unsigned    errors;

        function new();
            regs                = '0;
            regs.raster_op      = brop_pkg::ROP_COPY_SOURCE;
            regs.row_width_bits = brop_pkg::ROW_WIDTH_RESET;
            carry_word          = '0;
            aligned_src         = '0;
            expand_left         = 0;
            words_left          = 0;
            first_word          = 1'b1;
            errors              = 0;
        endfunction

        function void write_reg(logic [brop_pkg::CFG_IDX_W-1:0] index,
                                logic [brop_pkg::ROW_W-1:0] data);
            case (index)
                brop_pkg::CFG_RASTER_OP:      regs.raster_op      = data[3:0];
                brop_pkg::CFG_DST_BIT_OFFSET: regs.dst_bit_offset = data[brop_pkg::SHIFT_W-1:0];
                brop_pkg::CFG_SRC_BIT_OFFSET: regs.src_bit_offset = data[brop_pkg::SHIFT_W-1:0];
                brop_pkg::CFG_ROW_WIDTH_BITS: regs.row_width_bits = data;
                brop_pkg::CFG_SRC_LOG_DEPTH:  regs.src_log_depth  = data[1:0];
                brop_pkg::CFG_DST_LOG_DEPTH:  regs.dst_log_depth  = data[1:0];
                default: ;
            endcase
        endfunction

        // Replicate each source pixel 2^dd times; idx picks which slice of
        // the aligned word feeds this destination word.
        function logic [31:0] widen_pixels(logic [31:0] w, int unsigned sdep,
                                           int unsigned dd, int unsigned idx);
            logic [31:0] seg;
            logic [31:0] wide;
            int unsigned seg_bits, pix_bits, reps;
            int p, r, b;
            if (dd == 0)
                return w;
            seg_bits = 32 >> dd;
            pix_bits = 1 << sdep;
            reps     = 1 << dd;
            seg      = w >> (32 - seg_bits * (idx + 1));
            wide     = '0;
            for (p = 0; p < seg_bits / pix_bits; p++)
                for (r = 0; r < reps; r++)
                    for (b = 0; b < pix_bits; b++)
                        wide[(p * reps + r) * pix_bits + b] = seg[p * pix_bits + b];
            return wide;
        endfunction

        // Returns 1 when the request does real work (row start or in-row word).
        function bit note_request(bit mode, logic [31:0] src, logic [31:0] dst);
            int unsigned sdep, dd, nw, width, doff, idx, tail;
            int          shift;
            logic [63:0] pair;
            logic [31:0] expanded, lmask, rmask, mask, blended;
            row_word_t   res;
            int          i;
            sdep  = (regs.src_log_depth > regs.dst_log_depth) ?
                    regs.dst_log_depth : regs.src_log_depth;
            dd    = regs.dst_log_depth - sdep;
            nw    = 1 << dd;
            doff  = regs.dst_bit_offset;
            width = regs.row_width_bits;
            if (width == 0)
                width = 1;
            if (width > brop_pkg::MAX_ROW_BITS)
                width = brop_pkg::MAX_ROW_BITS;
            shift = int'(regs.src_bit_offset) - int'(doff >> dd);

            if (mode == MODE_ROW_START)
            begin
                words_left  = ((doff + width - 1) >> 5) + 1;
                first_word  = 1'b1;
                expand_left = 0;
                carry_word  = (shift >= 0) ? src : '0;
                return 1'b1;
            end
            if (words_left == 0)
                return 1'b0;

            res.taken = 1'b0;
            if (expand_left == 0)
            begin
                // funnel window over {carry, src}
                pair = {carry_word, src};
                if (shift < 0)
                    aligned_src = 32'(pair >> (-shift));
                else
                    aligned_src = 32'(pair >> (32 - shift));
                carry_word  = src;
                expand_left = nw - 1;
                idx         = 0;
                res.taken   = 1'b1;
            end
            else
            begin
                idx = (nw - expand_left) & (nw - 1);
                expand_left--;
            end
            expanded = widen_pixels(aligned_src, sdep, dd, idx);

            for (i = 0; i < 32; i++)
                blended[i] = regs.raster_op[{expanded[i], dst[i]}];

            lmask    = 32'hFFFF_FFFF >> doff;
            tail     = (doff + width) % 32;
            rmask    = (tail == 0) ? 32'hFFFF_FFFF : (32'hFFFF_FFFF << (32 - tail));
            mask     = first_word ? lmask : 32'hFFFF_FFFF;
            res.last = (words_left == 1);
            if (res.last)
                mask &= rmask;
            res.word = (dst & ~mask) | (blended & mask);

            first_word = 1'b0;
            words_left--;
            expected_words.push_back(res);
            return 1'b1;
        endfunction

        function void check_result(logic [31:0] word, logic taken, logic last);
            row_word_t exp_word;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result: new_dst_word %h", word);
                errors++;
                return;
            end
            exp_word = expected_words.pop_front();
            if (word !== exp_word.word)
            begin
                $error("new_dst_word: expected %h, got %h", exp_word.word, word);
                errors++;
            end
            if (taken !== exp_word.taken)
            begin
                $error("source_taken: expected %0d, got %0d", exp_word.taken, taken);
                errors++;
            end
            if (last !== exp_word.last)
            begin
                $error("last_in_row: expected %0d, got %0d", exp_word.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [brop_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [brop_pkg::ROW_W-1:0]     cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [63:0]                    s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [31:0]                    m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           m_axis_tlast;

    row_raster_model raster;
    bit              steady_flow;
    bit              hold_off_pending;
    int              work_items;
    int              quiet_cycles;

    bitblt_raster_op_row_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] rand_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h0;
        if (sel == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic logic [brop_pkg::SHIFT_W-1:0] rand_offset();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return brop_pkg::SHIFT_W'($urandom_range(0, 31));
    endfunction

    function automatic brop_pkg::cfg_t rand_setting();
        brop_pkg::cfg_t c;
        int unsigned    sel;
        c.raster_op      = 4'($urandom_range(0, 15));
        c.dst_bit_offset = rand_offset();
        c.src_bit_offset = rand_offset();
        c.src_log_depth  = 2'($urandom_range(0, 3));
        c.dst_log_depth  = 2'($urandom_range(0, 3));
        sel = $urandom_range(0, 99);
        if (sel < 6)
            c.row_width_bits = '0;
        else if (sel < 7)
            c.row_width_bits = brop_pkg::ROW_W'($urandom_range(brop_pkg::MAX_ROW_BITS, 16383));
        else if (sel < 14)
            c.row_width_bits = brop_pkg::ROW_W'(31 + $urandom_range(0, 2));
        else if (sel < 85)
            c.row_width_bits = brop_pkg::ROW_W'($urandom_range(1, 160));
        else
            c.row_width_bits = brop_pkg::ROW_W'($urandom_range(161, 600));
        return c;
    endfunction

    task automatic put_reg(input logic [brop_pkg::CFG_IDX_W-1:0] index,
                           input logic [brop_pkg::ROW_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        raster.write_reg(index, data);
    endtask

    task automatic write_all_regs(input brop_pkg::cfg_t c);
        put_reg(brop_pkg::CFG_RASTER_OP, brop_pkg::ROW_W'(c.raster_op));
        put_reg(brop_pkg::CFG_DST_BIT_OFFSET, brop_pkg::ROW_W'(c.dst_bit_offset));
        put_reg(brop_pkg::CFG_SRC_BIT_OFFSET, brop_pkg::ROW_W'(c.src_bit_offset));
        put_reg(brop_pkg::CFG_ROW_WIDTH_BITS, c.row_width_bits);
        put_reg(brop_pkg::CFG_SRC_LOG_DEPTH, brop_pkg::ROW_W'(c.src_log_depth));
        put_reg(brop_pkg::CFG_DST_LOG_DEPTH, brop_pkg::ROW_W'(c.dst_log_depth));
        cfg_we <= 1'b0;
    endtask

    // Call right after an edge; returns at the edge that accepts the request.
    task automatic send_request(input bit mode, input logic [31:0] src, input logic [31:0] dst);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {dst, src};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (raster.note_request(mode, src, dst))
            work_items++;
    endtask

    // Drain all results, then let requests that produce nothing retire.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (raster.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 10);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            raster.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[bitblt_raster_op_row_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        brop_pkg::cfg_t c;
        int             op, phase, rows, r, kind, n;
        raster           = new();
        steady_flow      = 1'b0;
        hold_off_pending = 1'b0;
        work_items       = 0;
        quiet_cycles     = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tuser     = 1'b0;
        s_axis_tdata     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // destination word with no row open: dropped
        send_request(MODE_DST_WORD, 32'hFFFF_FFFF, 32'h0);

        // every op on one long row; width above the maximum saturates
        c = raster.regs;
        c.row_width_bits = '1;
        for (op = 0; op < 16; op++)
        begin
            settle();
            c.raster_op = 4'(op);
            write_all_regs(c);
            if (op == 0)
                send_request(MODE_ROW_START, 32'hFFFF_FFFF, 32'h0);
            send_request(MODE_DST_WORD, 32'hCCCC_CCCC, 32'hAAAA_AAAA);
        end

        // zero width, last bit offset, source deeper than destination
        settle();
        c = '{raster_op: 4'd6, dst_bit_offset: 5'd31, src_bit_offset: 5'd0,
              row_width_bits: 14'd0, src_log_depth: 2'd3, dst_log_depth: 2'd1};
        write_all_regs(c);
        send_request(MODE_ROW_START, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_DST_WORD, 32'hFFFF_FFFF, 32'h0);

        // right edge on a word boundary, then a word past the end
        settle();
        c = '{raster_op: brop_pkg::ROP_COPY_SOURCE, dst_bit_offset: 5'd16,
              src_bit_offset: 5'd31, row_width_bits: 14'd48, src_log_depth: 2'd1,
              dst_log_depth: 2'd2};
        write_all_regs(c);
        send_request(MODE_ROW_START, 32'h0, 32'hFFFF_FFFF);
        send_request(MODE_DST_WORD, 32'h0, 32'hFFFF_FFFF);
        send_request(MODE_DST_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_DST_WORD, rand_word(), rand_word());

        // depth change mid-expansion leaves a stale slice index
        settle();
        c = '{raster_op: brop_pkg::ROP_COPY_SOURCE, dst_bit_offset: 5'd0,
              src_bit_offset: 5'd5, row_width_bits: 14'd256, src_log_depth: 2'd0,
              dst_log_depth: 2'd3};
        write_all_regs(c);
        send_request(MODE_ROW_START, 32'h8421_F00F, 32'h0);
        repeat (3) send_request(MODE_DST_WORD, rand_word(), rand_word());
        settle();
        c.dst_log_depth = 2'd1;
        write_all_regs(c);
        repeat (2) send_request(MODE_DST_WORD, rand_word(), rand_word());

        work_items = 0;
        phase = 0;
        while (work_items < RANDOM_ITEMS)
        begin
            settle();
            c = rand_setting();
            steady_flow = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                // long row with a stalled receiver: fill the unit until input backs up
                c.row_width_bits = 14'd1000;
                steady_flow      = 1'b1;
                hold_off_pending = 1'b1;
            end
            write_all_regs(c);
            rows = $urandom_range(1, 3);
            for (r = 0; r < rows; r++)
            begin
                kind = $urandom_range(0, 9);
                send_request(MODE_ROW_START, rand_word(), rand_word());
                n = raster.words_left;
                if (kind == 0)
                    n = $urandom_range(0, n - 1);
                else if (kind == 1)
                    n += $urandom_range(1, 3);
                // sometimes leave the row open across the next register update
                if (r == rows - 1 && phase != 3 && $urandom_range(0, 5) == 0)
                    n = n / 2;
                repeat (n) send_request(MODE_DST_WORD, rand_word(), rand_word());
            end
            phase++;
        end

        steady_flow = 1'b0;
        settle();
        if (raster.errors == 0 && raster.expected_words.size() == 0)
            $display("[bitblt_raster_op_row_unit] OK");
        else
            $display("[bitblt_raster_op_row_unit] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/brop_pkg.sv
design/brop_front.sv
design/brop_queue.sv
design/brop_back.sv
design/bitblt_raster_op_row_unit.sv
tb/tb_bitblt_raster_op_row_unit.sv
